@@ rtl/crt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package crt_pkg;

  // Table geometry
  localparam int unsigned DEF_SLOTS = 8;

  // Register reset values
  localparam logic [15:0] DEF_BASE_TIMEOUT = 16'd256;
  localparam logic [15:0] DEF_SPREAD       = 16'd128;
  localparam logic [3:0]  DEF_MAX_RETX     = 4'd4;

  // Register indexes
  localparam logic [1:0] REG_BASE_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_SPREAD       = 2'd1;
  localparam logic [1:0] REG_MAX_RETX     = 2'd2;

  // Request commands
  localparam logic [1:0] CMD_OPEN   = 2'd0;
  localparam logic [1:0] CMD_CLEAR  = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;
  localparam logic [1:0] CMD_TICK   = 2'd3;

  // Event codes
  localparam logic [3:0] EV_ARMED     = 4'd0;
  localparam logic [3:0] EV_RELEASED  = 4'd1;
  localparam logic [3:0] EV_RETX      = 4'd2;
  localparam logic [3:0] EV_TIMEOUT   = 4'd3;
  localparam logic [3:0] EV_CLEARED   = 4'd4;
  localparam logic [3:0] EV_NOT_FOUND = 4'd5;
  localparam logic [3:0] EV_FULL      = 4'd6;
  localparam logic [3:0] EV_FOUND     = 4'd7;
  localparam logic [3:0] EV_TICK_DONE = 4'd8;

endpackage

`default_nettype wire

@@ rtl/confirmable_retransmit_table.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Open: answered from idle when full, released or timed out, else after a 16-step remainder.
// Clear/lookup: one age-order position searched at a time, oldest first, up to SLOTS positions.
// Tick: walks each live entry in age order, then a done result; only the done result if empty.
// One request at a time: busy is high until its last result has been registered.
// Results are registered, each valid for one cycle; receiver cannot stall.
// Synchronous active-low reset empties the table and restores register defaults.
module confirmable_retransmit_table
  import crt_pkg::*;
#(
  parameter int unsigned SLOTS = DEF_SLOTS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [15:0] in_mid,
  input  wire logic        in_confirmable,
  input  wire logic [7:0]  in_message_handle,
  input  wire logic [15:0] in_random_value,
  output logic             out_valid,
  output logic [3:0]       out_event_res,
  output logic [2:0]       out_slot,
  output logic [15:0]      out_event_mid,
  output logic [7:0]       out_event_handle,
  output logic [3:0]       out_retransmissions,
  output logic             out_last,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W  = $clog2(SLOTS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_SEARCH,
    ST_WALK,
    ST_TDONE
  } state_t;

  state_t state_r;

  // Configuration
  logic [15:0] base_r;
  logic [15:0] spread_r;
  logic [3:0]  max_retx_r;

  // Table
  logic              live_r     [SLOTS];
  logic [15:0]       id_r       [SLOTS];
  logic [7:0]        buf_r      [SLOTS];
  logic [3:0]        retries_r  [SLOTS];
  logic [31:0]       interval_r [SLOTS];
  logic [31:0]       left_r     [SLOTS];
  logic [SLOT_W-1:0] age_r      [SLOTS];
  logic [CNT_W-1:0]  live_cnt_r;

  // Request latch and sequencer
  logic [1:0]        cmd_r;
  logic [15:0]       mid_r;
  logic [7:0]        hnd_r;
  logic [15:0]       rnd_r;
  logic [15:0]       rem_r;
  logic [3:0]        step_r;
  logic [SLOT_W-1:0] pos_r;
  logic [CNT_W-1:0]  todo_r;
  logic [SLOT_W-1:0] new_slot_r;

  // Result register
  logic        out_valid_r;
  logic [3:0]  out_ev_r;
  logic [2:0]  out_slot_r;
  logic [15:0] out_mid_r;
  logic [7:0]  out_hnd_r;
  logic [3:0]  out_retx_r;
  logic        out_last_r;

  // Lowest free slot
  logic [SLOT_W-1:0] free_slot;
  logic              free_any;
  always_comb begin
    free_slot = '0;
    free_any  = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!live_r[i] && !free_any) begin
        free_slot = SLOT_W'(i);
        free_any  = 1'b1;
      end
    end
  end

  // Entry at the current age position
  logic [SLOT_W-1:0] cur_slot;
  logic [31:0]       cur_left_dec;
  logic [3:0]        cur_retx_inc;
  logic [31:0]       cur_iv_dbl;
  assign cur_slot     = age_r[pos_r];
  assign cur_left_dec = (left_r[cur_slot] != '0) ? left_r[cur_slot] - 32'd1 : '0;
  assign cur_retx_inc = (retries_r[cur_slot] != 4'hF) ? retries_r[cur_slot] + 4'd1 : 4'hF;
  assign cur_iv_dbl   = interval_r[cur_slot][31] ? 32'hFFFF_FFFF
                                                 : {interval_r[cur_slot][30:0], 1'b0};

  // Remainder step: one bit of random value mod spread
  logic [16:0] trial;
  logic [15:0] rem_nxt;
  logic [31:0] armed_iv;
  assign trial    = {rem_r, rnd_r[15]};
  assign rem_nxt  = (trial >= {1'b0, spread_r}) ? 16'(trial - {1'b0, spread_r}) : trial[15:0];
  assign armed_iv = 32'(base_r) + ((spread_r == '0) ? 32'd0 : 32'(rem_nxt));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      base_r      <= DEF_BASE_TIMEOUT;
      spread_r    <= DEF_SPREAD;
      max_retx_r  <= DEF_MAX_RETX;
      live_cnt_r  <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
      for (int i = 0; i < SLOTS; i++) live_r[i] <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;

      // Register writes
      if (cfg_we) begin
        unique case (cfg_index)
          REG_BASE_TIMEOUT: base_r     <= cfg_data;
          REG_SPREAD:       spread_r   <= cfg_data;
          REG_MAX_RETX:     max_retx_r <= cfg_data[3:0];
          default: ;
        endcase
      end

      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            cmd_r  <= in_cmd;
            mid_r  <= in_mid;
            hnd_r  <= in_message_handle;
            rnd_r  <= in_random_value;
            pos_r  <= '0;
            todo_r <= live_cnt_r;
            out_mid_r  <= in_mid;
            out_hnd_r  <= in_message_handle;
            out_retx_r <= '0;
            out_slot_r <= '0;
            unique case (in_cmd)
              CMD_OPEN: begin
                if (!free_any || live_cnt_r >= CNT_W'(SLOTS)) begin
                  out_valid_r <= 1'b1;
                  out_last_r  <= 1'b1;
                  out_ev_r    <= EV_FULL;
                end else if (!in_confirmable || max_retx_r == '0) begin
                  // sent and released at once, never armed
                  out_valid_r <= 1'b1;
                  out_last_r  <= 1'b1;
                  out_ev_r    <= in_confirmable ? EV_TIMEOUT : EV_RELEASED;
                  out_slot_r  <= 3'(free_slot);
                end else begin
                  new_slot_r <= free_slot;
                  rem_r      <= '0;
                  step_r     <= '0;
                  state_r    <= ST_MOD;
                end
              end
              CMD_CLEAR, CMD_LOOKUP: begin
                if (live_cnt_r == '0) begin
                  out_valid_r <= 1'b1;
                  out_last_r  <= 1'b1;
                  out_ev_r    <= EV_NOT_FOUND;
                  out_hnd_r   <= '0;
                end else begin
                  state_r <= ST_SEARCH;
                end
              end
              default: begin
                if (live_cnt_r == '0) begin
                  out_valid_r <= 1'b1;
                  out_last_r  <= 1'b1;
                  out_ev_r    <= EV_TICK_DONE;
                  out_mid_r   <= '0;
                  out_hnd_r   <= '0;
                end else begin
                  state_r <= ST_WALK;
                end
              end
            endcase
          end
        end

        // Restoring remainder, MSB first, then arm the new entry
        ST_MOD: begin
          rem_r  <= rem_nxt;
          rnd_r  <= {rnd_r[14:0], 1'b0};
          step_r <= step_r + 4'd1;
          if (step_r == 4'hF) begin
            live_r[new_slot_r]     <= 1'b1;
            id_r[new_slot_r]       <= mid_r;
            buf_r[new_slot_r]      <= hnd_r;
            retries_r[new_slot_r]  <= '0;
            interval_r[new_slot_r] <= armed_iv;
            left_r[new_slot_r]     <= armed_iv;
            age_r[live_cnt_r[SLOT_W-1:0]] <= new_slot_r;
            live_cnt_r  <= live_cnt_r + CNT_W'(1);
            out_valid_r <= 1'b1;
            out_last_r  <= 1'b1;
            out_ev_r    <= EV_ARMED;
            out_slot_r  <= 3'(new_slot_r);
            state_r     <= ST_IDLE;
          end
        end

        // Oldest match first
        ST_SEARCH: begin
          if (id_r[cur_slot] == mid_r) begin
            out_valid_r <= 1'b1;
            out_last_r  <= 1'b1;
            out_ev_r    <= (cmd_r == CMD_CLEAR) ? EV_CLEARED : EV_FOUND;
            out_slot_r  <= 3'(cur_slot);
            out_mid_r   <= id_r[cur_slot];
            out_hnd_r   <= buf_r[cur_slot];
            out_retx_r  <= retries_r[cur_slot];
            if (cmd_r == CMD_CLEAR) begin
              live_r[cur_slot] <= 1'b0;
              for (int i = 0; i < SLOTS - 1; i++)
                if (SLOT_W'(i) >= pos_r) age_r[i] <= age_r[i+1];
              live_cnt_r <= live_cnt_r - CNT_W'(1);
            end
            state_r <= ST_IDLE;
          end else if (CNT_W'(pos_r) + CNT_W'(1) >= live_cnt_r) begin
            out_valid_r <= 1'b1;
            out_last_r  <= 1'b1;
            out_ev_r    <= EV_NOT_FOUND;
            out_hnd_r   <= '0;
            state_r     <= ST_IDLE;
          end else begin
            pos_r <= pos_r + SLOT_W'(1);
          end
        end

        // Tick walk, one entry per cycle in age order
        ST_WALK: begin
          todo_r <= todo_r - CNT_W'(1);
          if (todo_r == CNT_W'(1)) state_r <= ST_TDONE;
          if (cur_left_dec != '0) begin
            left_r[cur_slot] <= cur_left_dec;
            pos_r <= pos_r + SLOT_W'(1);
          end else begin
            retries_r[cur_slot] <= cur_retx_inc;
            out_valid_r <= 1'b1;
            out_slot_r  <= 3'(cur_slot);
            out_mid_r   <= id_r[cur_slot];
            out_hnd_r   <= buf_r[cur_slot];
            out_retx_r  <= cur_retx_inc;
            if (cur_retx_inc < max_retx_r) begin
              interval_r[cur_slot] <= cur_iv_dbl;
              left_r[cur_slot]     <= cur_iv_dbl;
              out_ev_r <= EV_RETX;
              pos_r    <= pos_r + SLOT_W'(1);
            end else begin
              // freed: later entries move down, position stays
              out_ev_r <= EV_TIMEOUT;
              live_r[cur_slot] <= 1'b0;
              for (int i = 0; i < SLOTS - 1; i++)
                if (SLOT_W'(i) >= pos_r) age_r[i] <= age_r[i+1];
              live_cnt_r <= live_cnt_r - CNT_W'(1);
            end
          end
        end

        ST_TDONE: begin
          out_valid_r <= 1'b1;
          out_last_r  <= 1'b1;
          out_ev_r    <= EV_TICK_DONE;
          out_slot_r  <= '0;
          out_mid_r   <= '0;
          out_hnd_r   <= '0;
          out_retx_r  <= '0;
          state_r     <= ST_IDLE;
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign busy                = (state_r != ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_event_res       = out_ev_r;
  assign out_slot            = out_slot_r;
  assign out_event_mid       = out_mid_r;
  assign out_event_handle    = out_hnd_r;
  assign out_retransmissions = out_retx_r;
  assign out_last            = out_last_r;

  // Live bits and the live count agree
  logic [SLOTS-1:0] live_vec;
  always_comb
    for (int i = 0; i < SLOTS; i++) live_vec[i] = live_r[i];

  a_live_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(live_vec) == 32'(live_cnt_r))
    else $error("live count differs from live bits");

  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_r |-> out_valid_r)
    else $error("last flag without result");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MOD && spread_r != '0) |-> (rem_r < spread_r))
    else $error("remainder out of range");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && out_last_r) |-> $past(state_r == ST_IDLE))
    else $error("last result while a request is still open");

endmodule

`default_nettype wire
